FILE: sv/vis_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vis_pkg
// Shared types and constants of the valve interlock and ignition sequencer.
// ----------------------------------------------------------------------------
package vis_pkg;

    localparam int unsigned CFG_W  = 16;
    localparam int unsigned CFG_IW = 2;
    localparam int unsigned CMD_W  = 8;
    localparam int unsigned MSG_W  = 5;

    localparam logic [CFG_W-1:0] PRE_DELAY_RST   = 16'd1000;
    localparam logic [CFG_W-1:0] IGNITER_RST     = 16'd4000;
    localparam logic [CFG_W-1:0] RV_EXTRA_RST    = 16'd500;
    localparam logic [CFG_W-1:0] RUN_WINDOW_RST  = 16'd20000;

    typedef enum logic [CFG_IW-1:0] {
        REG_PRE_DELAY  = 2'd0,
        REG_IGNITER    = 2'd1,
        REG_RV_EXTRA   = 2'd2,
        REG_RUN_WINDOW = 2'd3
    } t_reg_idx;

    localparam logic [CMD_W-1:0] CH_DUMP_OPEN  = 8'h44; // D
    localparam logic [CMD_W-1:0] CH_DUMP_CLOSE = 8'h64; // d
    localparam logic [CMD_W-1:0] CH_FILL_OPEN  = 8'h46; // F
    localparam logic [CMD_W-1:0] CH_FILL_CLOSE = 8'h66; // f
    localparam logic [CMD_W-1:0] CH_VENT_CLOSE = 8'h49; // I
    localparam logic [CMD_W-1:0] CH_VENT_OPEN  = 8'h69; // i
    localparam logic [CMD_W-1:0] CH_ARM        = 8'h41; // A
    localparam logic [CMD_W-1:0] CH_DISARM     = 8'h61; // a
    localparam logic [CMD_W-1:0] CH_FIRE       = 8'h4F; // O
    localparam logic [CMD_W-1:0] CH_DISABLE    = 8'h6F; // o
    localparam logic [CMD_W-1:0] CH_ABORT      = 8'h58; // X
    localparam logic [CMD_W-1:0] CH_STATUS     = 8'h53; // S
    localparam logic [CMD_W-1:0] CH_YES        = 8'h59; // Y
    localparam logic [CMD_W-1:0] CH_NO         = 8'h4E; // N

    localparam logic OP_TICK = 1'b0;

    typedef enum logic [MSG_W-1:0] {
        MSG_NONE         = 5'd0,
        MSG_DUMP_OPEN    = 5'd1,
        MSG_DUMP_REFUSED = 5'd2,
        MSG_DUMP_CLOSED  = 5'd3,
        MSG_FILL_OPEN    = 5'd4,
        MSG_FILL_REFUSED = 5'd5,
        MSG_FILL_CLOSED  = 5'd6,
        MSG_VENT_CLOSED  = 5'd7,
        MSG_VENT_OPEN    = 5'd8,
        MSG_ARM_PROMPT   = 5'd9,
        MSG_ARM_REFUSED  = 5'd10,
        MSG_ARMED        = 5'd11,
        MSG_ARM_CANCEL   = 5'd12,
        MSG_REPROMPT     = 5'd13,
        MSG_DISARMED     = 5'd14,
        MSG_COUNTDOWN    = 5'd15,
        MSG_DISABLED     = 5'd16,
        MSG_IGNITE       = 5'd17,
        MSG_RUN_VALVE    = 5'd18,
        MSG_FIRED        = 5'd19,
        MSG_STATUS       = 5'd20
    } t_msg;

    typedef struct packed {
        logic [CFG_W-1:0] pre_delay;
        logic [CFG_W-1:0] igniter_time;
        logic [CFG_W-1:0] rv_extra;
        logic [CFG_W-1:0] run_window;
    } t_cfg;

    typedef struct packed {
        logic dump_open;
        logic fill_open;
        logic vent_open;
        logic arm_drive;
        logic igniter_drive;
        logic run_valve_drive;
        logic armed;
        logic awaiting_confirm;
        logic sequence_active;
        t_msg message;
    } t_result;

endpackage

FILE: sv/vis_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vis_cfg_regs
// Timing configuration registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module vis_cfg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [vis_pkg::CFG_IW-1:0]  i_cfg_index,
    input  logic [vis_pkg::CFG_W-1:0]   i_cfg_data,
    output vis_pkg::t_cfg               o_cfg
);
    import vis_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pre_delay    <= PRE_DELAY_RST;
            r_cfg.igniter_time <= IGNITER_RST;
            r_cfg.rv_extra     <= RV_EXTRA_RST;
            r_cfg.run_window   <= RUN_WINDOW_RST;
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_PRE_DELAY:  r_cfg.pre_delay    <= i_cfg_data;
                REG_IGNITER:    r_cfg.igniter_time <= i_cfg_data;
                REG_RV_EXTRA:   r_cfg.rv_extra     <= i_cfg_data;
                REG_RUN_WINDOW: r_cfg.run_window   <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

FILE: sv/vis_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vis_core
// Interlock and sequence state with the single-pass update for one item.
// ----------------------------------------------------------------------------
module vis_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_fire,
    input  logic                       i_opcode,
    input  logic [vis_pkg::CMD_W-1:0]  i_command_byte,
    input  vis_pkg::t_cfg              i_cfg,
    output vis_pkg::t_result           o_result
);
    import vis_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_PRE    = 2'd1,
        PH_RUN    = 2'd2,
        PH_UNUSED = 2'd3
    } t_phase;

    logic             r_dump, r_fill, r_vent, r_arm, r_ign, r_rv, r_armed, r_wait;
    t_phase           r_phase;
    logic [CFG_W-1:0] r_timer;

    logic             n_dump, n_fill, n_vent, n_arm, n_ign, n_rv, n_armed, n_wait;
    t_phase           n_phase;
    logic [CFG_W-1:0] n_timer;
    t_msg             n_msg;

    logic             active;
    logic [CFG_W-1:0] t_next;
    logic [CFG_W-1:0] ign_at;
    logic [CFG_W:0]   rv_sum;
    logic [CFG_W:0]   rv_at;
    logic [CFG_W-1:0] win_at;

    assign active = (r_phase == PH_PRE) || (r_phase == PH_RUN);
    assign t_next = r_timer + 1'b1;
    assign ign_at = (i_cfg.igniter_time == '0) ? CFG_W'(1) : i_cfg.igniter_time;
    assign rv_sum = {1'b0, i_cfg.igniter_time} + {1'b0, i_cfg.rv_extra};
    assign rv_at  = (rv_sum == '0) ? (CFG_W+1)'(1) : rv_sum;
    assign win_at = (i_cfg.run_window == '0) ? CFG_W'(1) : i_cfg.run_window;

    always_comb begin
        n_dump  = r_dump;
        n_fill  = r_fill;
        n_vent  = r_vent;
        n_arm   = r_arm;
        n_ign   = r_ign;
        n_rv    = r_rv;
        n_armed = r_armed;
        n_wait  = r_wait;
        n_phase = r_phase;
        n_timer = r_timer;
        n_msg   = MSG_NONE;
        if (i_opcode == OP_TICK) begin
            if (r_phase == PH_PRE) begin
                n_timer = t_next;
                if (t_next >= i_cfg.pre_delay) begin
                    n_phase = PH_RUN;
                    n_timer = '0;
                end
            end else if (r_phase == PH_RUN) begin
                n_timer = t_next;
                if (t_next == ign_at) begin
                    n_ign = 1'b1;
                    n_msg = MSG_IGNITE;
                end
                if ({1'b0, t_next} == rv_at) begin
                    n_rv  = 1'b1;
                    n_msg = MSG_RUN_VALVE;
                end
                if (t_next >= win_at) begin
                    n_phase = PH_IDLE;
                    n_timer = '0;
                    n_msg   = MSG_FIRED;
                end
            end
        end else if (active) begin
            if (i_command_byte == CH_DISABLE || i_command_byte == CH_ABORT) begin
                n_ign   = 1'b0;
                n_rv    = 1'b0;
                n_arm   = 1'b0;
                n_phase = PH_IDLE;
                n_timer = '0;
                n_msg   = MSG_DISABLED;
            end
        end else if (r_wait) begin
            if (i_command_byte == CH_YES) begin
                n_arm   = 1'b1;
                n_armed = 1'b1;
                n_wait  = 1'b0;
                n_msg   = MSG_ARMED;
            end else if (i_command_byte == CH_NO) begin
                n_wait = 1'b0;
                n_msg  = MSG_ARM_CANCEL;
            end else begin
                n_msg = MSG_REPROMPT;
            end
        end else begin
            n_phase = PH_IDLE;
            unique case (i_command_byte)
                CH_DUMP_OPEN: begin
                    if (!r_fill) begin
                        n_dump = 1'b1;
                        n_msg  = MSG_DUMP_OPEN;
                    end else begin
                        n_msg = MSG_DUMP_REFUSED;
                    end
                end
                CH_DUMP_CLOSE: begin
                    n_dump = 1'b0;
                    n_msg  = MSG_DUMP_CLOSED;
                end
                CH_FILL_OPEN: begin
                    if (!r_dump) begin
                        n_fill = 1'b1;
                        n_msg  = MSG_FILL_OPEN;
                    end else begin
                        n_msg = MSG_FILL_REFUSED;
                    end
                end
                CH_FILL_CLOSE: begin
                    n_fill = 1'b0;
                    n_msg  = MSG_FILL_CLOSED;
                end
                CH_VENT_CLOSE: begin
                    n_vent = 1'b0;
                    n_msg  = MSG_VENT_CLOSED;
                end
                CH_VENT_OPEN: begin
                    n_vent = 1'b1;
                    n_msg  = MSG_VENT_OPEN;
                end
                CH_ARM: begin
                    if (!r_dump && !r_fill && !r_vent) begin
                        n_wait = 1'b1;
                        n_msg  = MSG_ARM_PROMPT;
                    end else begin
                        n_msg = MSG_ARM_REFUSED;
                    end
                end
                CH_DISARM: begin
                    n_arm   = 1'b0;
                    n_armed = 1'b0;
                    n_msg   = MSG_DISARMED;
                end
                CH_FIRE: begin
                    if (r_armed) begin
                        n_timer = '0;
                        n_phase = (i_cfg.pre_delay == '0) ? PH_RUN : PH_PRE;
                        n_msg   = MSG_COUNTDOWN;
                    end
                end
                CH_DISABLE: begin
                    n_ign = 1'b0;
                    n_rv  = 1'b0;
                    n_arm = 1'b0;
                    n_msg = MSG_DISABLED;
                end
                CH_STATUS: n_msg = MSG_STATUS;
                default:   n_msg = MSG_NONE;
            endcase
        end
    end

    always_comb begin
        o_result.dump_open        = n_dump;
        o_result.fill_open        = n_fill;
        o_result.vent_open        = n_vent;
        o_result.arm_drive        = n_arm;
        o_result.igniter_drive    = n_ign;
        o_result.run_valve_drive  = n_rv;
        o_result.armed            = n_armed;
        o_result.awaiting_confirm = n_wait;
        o_result.sequence_active  = (n_phase == PH_PRE) || (n_phase == PH_RUN);
        o_result.message          = n_msg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dump  <= 1'b0;
            r_fill  <= 1'b0;
            r_vent  <= 1'b1;
            r_arm   <= 1'b0;
            r_ign   <= 1'b0;
            r_rv    <= 1'b0;
            r_armed <= 1'b0;
            r_wait  <= 1'b0;
            r_phase <= PH_IDLE;
            r_timer <= '0;
        end else if (i_fire) begin
            r_dump  <= n_dump;
            r_fill  <= n_fill;
            r_vent  <= n_vent;
            r_arm   <= n_arm;
            r_ign   <= n_ign;
            r_rv    <= n_rv;
            r_armed <= n_armed;
            r_wait  <= n_wait;
            r_phase <= n_phase;
            r_timer <= n_timer;
        end
    end

endmodule

FILE: sv/vis_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vis_out_stage
// Result register holding one finished result until its transfer.
// ----------------------------------------------------------------------------
module vis_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  vis_pkg::t_result  i_result,
    output logic              o_free,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output vis_pkg::t_result  o_result
);
    import vis_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_free      = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_result    = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

FILE: sv/valve_interlock_ignition_sequencer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// valve_interlock_ignition_sequencer_top
// Valve interlock, arming handshake and timed ignition sequence driven by
// command bytes and millisecond ticks; one result per input item.
//
//   channel  direction  handshake                 payload
//   in       input      i_in_valid / o_in_ready   i_opcode, i_command_byte
//   out      output     o_out_valid / i_out_ready drive flags, o_message
//   cfg      input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One item per cycle while the output is not stalled; an item passes the
// input register, then the state update into the result register.
// Synchronous active-low reset restores valve flags, drives and timings.
// A stalled output holds the result register; the input register keeps
// accepting while that register frees in the same cycle.
// ----------------------------------------------------------------------------
module valve_interlock_ignition_sequencer_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_opcode,
    input  logic [vis_pkg::CMD_W-1:0]   i_command_byte,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_dump_open,
    output logic                        o_fill_open,
    output logic                        o_vent_open,
    output logic                        o_arm_drive,
    output logic                        o_igniter_drive,
    output logic                        o_run_valve_drive,
    output logic                        o_armed,
    output logic                        o_awaiting_confirm,
    output logic                        o_sequence_active,
    output logic [vis_pkg::MSG_W-1:0]   o_message,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [vis_pkg::CFG_IW-1:0]  i_cfg_index,
    input  logic [vis_pkg::CFG_W-1:0]   i_cfg_data
);
    import vis_pkg::*;

    logic             r_in_valid;
    logic             r_opcode;
    logic [CMD_W-1:0] r_cmd;
    logic             out_free;
    logic             fire;
    t_cfg             cfg;
    t_result          core_result;
    t_result          out_result;

    assign fire       = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_opcode <= i_opcode;
            r_cmd    <= i_command_byte;
        end
    end

    vis_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    vis_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_opcode       (r_opcode),
        .i_command_byte (r_cmd),
        .i_cfg          (cfg),
        .o_result       (core_result)
    );

    vis_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (fire),
        .i_result    (core_result),
        .o_free      (out_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (out_result)
    );

    assign o_dump_open        = out_result.dump_open;
    assign o_fill_open        = out_result.fill_open;
    assign o_vent_open        = out_result.vent_open;
    assign o_arm_drive        = out_result.arm_drive;
    assign o_igniter_drive    = out_result.igniter_drive;
    assign o_run_valve_drive  = out_result.run_valve_drive;
    assign o_armed            = out_result.armed;
    assign o_awaiting_confirm = out_result.awaiting_confirm;
    assign o_sequence_active  = out_result.sequence_active;
    assign o_message          = out_result.message;

endmodule
